// ===== src/md5_pkg.sv =====
// Shared types, constants and round helpers for the MD5 digest core.
package md5_pkg;

  // Input beat: one message byte, its presence flag and the end-of-message mark.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       final_req;
  } in_item_t;

  // Output beat: one digest word with its position.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Back end status, seen by the top level.
  typedef struct packed {
    logic busy;
    logic draining;
  } back_status_t;

  localparam int QUEUE_DEPTH = 4;

  // Round passes.
  localparam logic [1:0] PASS_F = 2'd0;
  localparam logic [1:0] PASS_G = 2'd1;
  localparam logic [1:0] PASS_H = 2'd2;
  localparam logic [1:0] PASS_I = 2'd3;

  // Initial chaining value, A first.
  localparam logic [31:0] INIT_CV [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  // Pad byte and buffer positions.
  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [3:0] LEN_LO_WORD = 4'd14;
  localparam logic [3:0] LEN_HI_WORD = 4'd15;

  // Additive constants, one for each round.
  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts, indexed by pass and the low two bits of the round.
  localparam logic [4:0] ROT_AMT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  // Message word used by a round.
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] j;
    logic [3:0] idx;
    j = rnd[3:0];
    case (rnd[5:4])
      PASS_F:  idx = j;
      PASS_G:  idx = j * 4'd5 + 4'd1;
      PASS_H:  idx = j * 4'd3 + 4'd5;
      default: idx = j * 4'd7;
    endcase
    return idx;
  endfunction

  // Boolean function of the pass.
  function automatic logic [31:0] round_fn(input logic [1:0] pass,
                                           input logic [31:0] b,
                                           input logic [31:0] c,
                                           input logic [31:0] d);
    logic [31:0] f;
    case (pass)
      PASS_F:  f = (b & c) | (~b & d);
      PASS_G:  f = (b & d) | (c & ~d);
      PASS_H:  f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  // Left rotate of a 32-bit word.
  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {v, v} << s;
    return dbl[63:32];
  endfunction

endpackage

// ===== src/md5_front.sv =====
// Front end: takes input beats, drops empty ones and holds the rest for the queue.
module md5_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  md5_pkg::in_item_t in_data,
  output logic              q_push,
  output md5_pkg::in_item_t q_data,
  input  logic              q_full
);

  logic              hold_valid_r;
  md5_pkg::in_item_t hold_r;
  logic              accept;
  logic              keep;

  // The holding register frees itself whenever the queue has room.
  assign in_stall = hold_valid_r & q_full;
  assign accept   = in_valid & ~in_stall;
  assign q_push   = hold_valid_r & ~q_full;
  assign q_data   = hold_r;

  // A beat with neither a byte nor the end mark changes nothing and is dropped.
  assign keep = in_data.byte_present | in_data.final_req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (accept) begin
      hold_valid_r <= keep;
      hold_r       <= in_data;
    end else if (q_push) begin
      hold_valid_r <= 1'b0;
    end
  end

endmodule

// ===== src/md5_q.sv =====
// Short first-in first-out queue between the front and back ends.
module md5_q #(
  parameter int DEPTH = md5_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  md5_pkg::in_item_t push_data,
  output logic              full,
  input  logic              pop,
  output md5_pkg::in_item_t pop_data,
  output logic              not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  md5_pkg::in_item_t  mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push;
  logic               do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;

  // Pointers wrap at the depth, which need not be a power of two.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        mem_r[wr_ptr_r] <= push_data;
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== src/md5_back.sv =====
// Back end: block buffer, padding, the round engine and the digest output register.
module md5_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  md5_pkg::in_item_t     q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output md5_pkg::out_item_t    out_data,
  output md5_pkg::back_status_t status
);

  typedef enum logic [2:0] {
    S_TAKE, S_PAD, S_LOAD, S_RUN, S_ADD, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    AR_TAKE, AR_PAD, AR_OUT
  } after_t;

  state_t             state_r;
  after_t             after_r;
  logic [31:0]        blk_r [16];
  logic [31:0]        cv_r [4];
  logic [31:0]        wr_r [4];
  logic [31:0]        km_r;
  logic [63:0]        count_r;
  logic [5:0]         fill_r;
  logic [5:0]         round_r;
  logic [3:0]         pw_r;
  logic               pad_second_r;
  logic [1:0]         out_idx_r;
  logic               out_valid_r;
  md5_pkg::out_item_t out_r;

  logic [3:0]  fill_word;
  logic [1:0]  fill_lane;
  logic [5:0]  fill_inc;
  logic        two_blk;
  logic [5:0]  rd_idx;
  logic [3:0]  rd_addr;
  logic [31:0] rd_word;
  logic [31:0] km_nxt;
  logic [31:0] pad_word;
  logic [31:0] masked_word;
  logic [31:0] fn_val;
  logic [31:0] t_sum;
  logic [31:0] b_nxt;

  assign fill_word = fill_r[5:2];
  assign fill_lane = fill_r[1:0];
  assign fill_inc  = fill_r + 6'd1;
  assign two_blk   = (fill_r[5:3] == 3'b111);

  assign q_pop     = (state_r == S_TAKE) & q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign status.busy     = (state_r == S_LOAD) | (state_r == S_RUN) | (state_r == S_ADD);
  assign status.draining = (state_r == S_OUT);

  // One read port on the block buffer: padding reads its word, the rounds prefetch.
  always_comb begin
    rd_idx  = (state_r == S_RUN) ? round_r + 6'd1 : 6'd0;
    rd_addr = (state_r == S_PAD) ? pw_r : md5_pkg::msg_index(rd_idx);
    rd_word = blk_r[rd_addr];
    km_nxt  = rd_word + md5_pkg::ROUND_K[rd_idx];
  end

  // The first pad word keeps the bytes already held and places the pad byte after them.
  always_comb begin
    case (fill_lane)
      2'd0:    masked_word = {24'h0, md5_pkg::PAD_BYTE};
      2'd1:    masked_word = {16'h0, md5_pkg::PAD_BYTE, rd_word[7:0]};
      2'd2:    masked_word = {8'h0, md5_pkg::PAD_BYTE, rd_word[15:0]};
      default: masked_word = {md5_pkg::PAD_BYTE, rd_word[23:0]};
    endcase
  end

  // Word written by the padding sweep.
  always_comb begin
    pad_word = 32'h0;
    if (pad_second_r || !two_blk) begin
      if (pw_r == md5_pkg::LEN_LO_WORD) begin
        pad_word = count_r[31:0];
      end else if (pw_r == md5_pkg::LEN_HI_WORD) begin
        pad_word = count_r[63:32];
      end
    end
    if (!pad_second_r && (pw_r == fill_word)) begin
      pad_word = masked_word;
    end
  end

  // One round: the message word and constant were summed in the cycle before.
  always_comb begin
    fn_val = md5_pkg::round_fn(round_r[5:4], wr_r[1], wr_r[2], wr_r[3]);
    t_sum  = wr_r[0] + fn_val + km_r;
    b_nxt  = wr_r[1] + md5_pkg::rotl32(t_sum, md5_pkg::ROT_AMT[{round_r[5:4], round_r[1:0]}]);
  end

  // Sequencer with its registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_TAKE;
      after_r      <= AR_TAKE;
      cv_r         <= md5_pkg::INIT_CV;
      count_r      <= 64'h0;
      fill_r       <= 6'd0;
      round_r      <= 6'd0;
      pw_r         <= 4'd0;
      pad_second_r <= 1'b0;
      out_idx_r    <= 2'd0;
      out_valid_r  <= 1'b0;
    end else begin
      // A taken beat empties the output register unless the next word replaces it.
      if (out_valid_r && !out_stall && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_TAKE: begin
          if (q_valid) begin
            pad_second_r <= 1'b0;
            if (q_data.byte_present) begin
              blk_r[fill_word][{fill_lane, 3'b000} +: 8] <= q_data.data_byte;
              count_r <= count_r + 64'd8;
              fill_r  <= fill_inc;
              if (fill_r == 6'd63) begin
                state_r <= S_LOAD;
                after_r <= q_data.final_req ? AR_PAD : AR_TAKE;
                pw_r    <= 4'd0;
              end else if (q_data.final_req) begin
                state_r <= S_PAD;
                pw_r    <= fill_inc[5:2];
              end
            end else begin
              state_r <= S_PAD;
              pw_r    <= fill_word;
            end
          end
        end
        S_PAD: begin
          blk_r[pw_r] <= pad_word;
          if (pw_r == 4'd15) begin
            state_r <= S_LOAD;
            if (two_blk && !pad_second_r) begin
              after_r      <= AR_PAD;
              pad_second_r <= 1'b1;
              pw_r         <= 4'd0;
            end else begin
              after_r <= AR_OUT;
            end
          end else begin
            pw_r <= pw_r + 4'd1;
          end
        end
        S_LOAD: begin
          wr_r    <= cv_r;
          km_r    <= km_nxt;
          round_r <= 6'd0;
          state_r <= S_RUN;
        end
        S_RUN: begin
          wr_r[0] <= wr_r[3];
          wr_r[1] <= b_nxt;
          wr_r[2] <= wr_r[1];
          wr_r[3] <= wr_r[2];
          km_r    <= km_nxt;
          round_r <= round_r + 6'd1;
          if (round_r == 6'd63) begin
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          for (int k = 0; k < 4; k++) begin
            cv_r[k] <= cv_r[k] + wr_r[k];
          end
          out_idx_r <= 2'd0;
          unique case (after_r)
            AR_PAD:  state_r <= S_PAD;
            AR_OUT:  state_r <= S_OUT;
            default: state_r <= S_TAKE;
          endcase
        end
        S_OUT: begin
          // Each digest word goes into the output register once it is free.
          if (!out_valid_r || !out_stall) begin
            out_valid_r       <= 1'b1;
            out_r.digest_word <= cv_r[out_idx_r];
            out_r.word_index  <= out_idx_r;
            out_r.last_word   <= (out_idx_r == 2'd3);
            out_idx_r         <= out_idx_r + 2'd1;
            if (out_idx_r == 2'd3) begin
              cv_r    <= md5_pkg::INIT_CV;
              count_r <= 64'h0;
              fill_r  <= 6'd0;
              state_r <= S_TAKE;
            end
          end
        end
        default: state_r <= S_TAKE;
      endcase
    end
  end

endmodule

// ===== src/md5_message_digest_core.sv =====
// Byte-serial MD5 digest core: front end, queue, back end and checks.
// A byte beat that does not fill a block is stored in the buffer; the 64th byte of a block
// starts a compression (load, 64 rounds of the single round unit, add), during which no
// bytes are taken from the queue. The end-of-message beat adds a padding sweep,
// one or two compressions and four output beats.
// Synchronous active-low reset loads the initial chaining value and clears the count.
module md5_message_digest_core #(
  parameter int QUEUE_DEPTH = md5_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  md5_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output md5_pkg::out_item_t out_data
);

  logic                  q_push;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_valid;
  md5_pkg::in_item_t     q_in;
  md5_pkg::in_item_t     q_out;
  md5_pkg::back_status_t status;

  md5_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_in),
    .q_full   (q_full)
  );

  md5_q #(
    .DEPTH (QUEUE_DEPTH)
  ) u_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .not_empty (q_valid)
  );

  md5_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .status    (status)
  );

  // A digest always starts with word A.
  a_digest_starts: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_data.word_index == 2'd0)
    else $error("digest output did not start with the first word");

  // Words of one digest follow each other without a gap once a beat is taken.
  a_digest_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_data.last_word) |=>
      (out_valid && out_data.word_index == $past(out_data.word_index) + 2'd1))
    else $error("digest words out of order");

  // The queue is left alone while a block is compressed or the digest drains.
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (status.busy || status.draining) |-> !q_pop)
    else $error("queue popped while the back end was busy");

endmodule

// ===== bench/md5_message_digest_core_test.sv =====
// Self-checking bench for the byte-serial MD5 core, with its own digest predictor.
module md5_message_digest_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 1500;
  localparam int DRAIN_CYCLES = 300;
  localparam int IDLE_PCT     = 7;
  localparam int NOISE_PCT    = 8;
  localparam int TOTAL_BEATS  = 160;
  localparam int REPORT_LIMIT = 10;
  localparam int LENGTH_AT    = 56;
  localparam int BLOCK_LEN    = 64;

  // Where the expected digest of a message comes from.
  typedef enum logic [1:0] {EXP_PREDICTED, EXP_EMPTY_MSG, EXP_ABC_MSG} digest_src_t;

  typedef struct packed {
    md5_pkg::in_item_t beat;
    digest_src_t       src;
  } stim_row_t;

  // Well-known digests, words little-endian as the core emits them.
  localparam logic [31:0] EMPTY_DIGEST [4] = '{
    32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec
  };
  localparam logic [31:0] ABC_DIGEST [4] = '{
    32'h98500190, 32'hb04fd23c, 32'h7d3f96d6, 32'h727fe128
  };

  localparam int unsigned SHIFT_BY [4][4] = '{
    '{7, 12, 17, 22}, '{5, 9, 14, 20}, '{4, 11, 16, 23}, '{6, 10, 15, 21}
  };

  // Directed beats: ignored beats, empty message, "abc" both ways, extreme bytes.
  localparam stim_row_t DIRECTED [17] = '{
    '{'{8'h00, 1'b0, 1'b0}, EXP_PREDICTED},
    '{'{8'hff, 1'b0, 1'b0}, EXP_PREDICTED},
    '{'{8'h00, 1'b0, 1'b1}, EXP_EMPTY_MSG},
    '{'{8'hff, 1'b0, 1'b1}, EXP_EMPTY_MSG},
    '{'{8'h61, 1'b1, 1'b0}, EXP_PREDICTED},
    '{'{8'h5a, 1'b0, 1'b0}, EXP_PREDICTED},
    '{'{8'h62, 1'b1, 1'b0}, EXP_PREDICTED},
    '{'{8'h63, 1'b1, 1'b1}, EXP_ABC_MSG},
    '{'{8'h61, 1'b1, 1'b0}, EXP_PREDICTED},
    '{'{8'h62, 1'b1, 1'b0}, EXP_PREDICTED},
    '{'{8'h63, 1'b1, 1'b0}, EXP_PREDICTED},
    '{'{8'h00, 1'b0, 1'b1}, EXP_ABC_MSG},
    '{'{8'hff, 1'b1, 1'b0}, EXP_PREDICTED},
    '{'{8'h00, 1'b1, 1'b0}, EXP_PREDICTED},
    '{'{8'hff, 1'b1, 1'b0}, EXP_PREDICTED},
    '{'{8'h00, 1'b1, 1'b1}, EXP_PREDICTED},
    '{'{8'hff, 1'b1, 1'b1}, EXP_PREDICTED}
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  md5_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  md5_pkg::out_item_t out_data;

  md5_message_digest_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Predictor state: chaining words, block buffer, length and fill.
  logic [31:0] chain_words [4];
  logic [31:0] block_buf [16];
  logic [63:0] bit_length;
  logic [5:0]  fill_bytes;
  logic [31:0] digest_out [4];

  // Stimulus and bookkeeping.
  stim_row_t stim_q [$];
  md5_pkg::out_item_t digest_due [$];
  int send_idx       = 0;
  int accepted_cnt   = 0;
  int cycle_count    = 0;
  int fail_count     = 0;
  int words_checked  = 0;
  int messages_seen  = 0;
  int stall_seen     = 0;
  int burst_at       = 0;
  int calm_from      = 0;
  int calm_to        = 0;
  int hold_left      = 0;
  bit hold_started   = 1'b0;
  bit in_taken       = 1'b0;

  wire calm = (accepted_cnt >= calm_from) && (accepted_cnt < calm_to);

  function automatic logic [31:0] rotate_left(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void store_byte(input int pos, input logic [7:0] value);
    block_buf[pos / 4][(pos % 4) * 8 +: 8] = value;
  endfunction

  // One 64-round compression of the block buffer into the chaining words.
  function automatic void compress_block();
    logic [31:0] a, b, c, d, f, t;
    logic [1:0]  pass;
    int          g;
    a = chain_words[0];
    b = chain_words[1];
    c = chain_words[2];
    d = chain_words[3];
    for (int i = 0; i < 64; i++) begin
      pass = 2'(i / 16);
      case (pass)
        md5_pkg::PASS_F: begin
          f = (b & c) | (~b & d);
          g = i % 16;
        end
        md5_pkg::PASS_G: begin
          f = (b & d) | (c & ~d);
          g = (5 * i + 1) % 16;
        end
        md5_pkg::PASS_H: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      t = a + f + block_buf[g] + md5_pkg::ROUND_K[i];
      t = b + rotate_left(t, SHIFT_BY[pass][i % 4]);
      a = d;
      d = c;
      c = b;
      b = t;
    end
    chain_words[0] += a;
    chain_words[1] += b;
    chain_words[2] += c;
    chain_words[3] += d;
  endfunction

  function automatic void restart_message();
    chain_words = md5_pkg::INIT_CV;
    bit_length  = '0;
    fill_bytes  = '0;
  endfunction

  // Takes one beat; returns 1 when it finishes a message, digest in digest_out.
  function automatic bit absorb_beat(input md5_pkg::in_item_t beat);
    if (beat.byte_present) begin
      store_byte(int'(fill_bytes), beat.data_byte);
      bit_length += 64'd8;
      fill_bytes += 6'd1;
      if (fill_bytes == 6'd0) begin
        compress_block();
      end
    end
    if (!beat.final_req) begin
      return 1'b0;
    end
    store_byte(int'(fill_bytes), md5_pkg::PAD_BYTE);
    // No room for the length: close this block and start a block of zeros.
    if (int'(fill_bytes) >= LENGTH_AT) begin
      for (int p = int'(fill_bytes) + 1; p < BLOCK_LEN; p++) store_byte(p, 8'h00);
      compress_block();
      for (int p = 0; p < LENGTH_AT; p++) store_byte(p, 8'h00);
    end else begin
      for (int p = int'(fill_bytes) + 1; p < LENGTH_AT; p++) store_byte(p, 8'h00);
    end
    block_buf[md5_pkg::LEN_LO_WORD] = bit_length[31:0];
    block_buf[md5_pkg::LEN_HI_WORD] = bit_length[63:32];
    compress_block();
    digest_out = chain_words;
    restart_message();
    return 1'b1;
  endfunction

  function automatic void push_beat(input logic [7:0] d, input bit present, input bit fin);
    stim_q.push_back('{'{d, present, fin}, EXP_PREDICTED});
  endfunction

  // One message of random bytes; the last byte may ride on the end beat.
  function automatic void add_message(input int len, input bit ride);
    int body;
    body = (ride && len > 0) ? len - 1 : len;
    for (int n = 0; n < body; n++) begin
      if ($urandom_range(0, 99) < NOISE_PCT) begin
        push_beat(8'($urandom), 1'b0, 1'b0);
      end
      push_beat(8'($urandom), 1'b1, 1'b0);
    end
    push_beat(8'($urandom), ride && len > 0, 1'b1);
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the cycle count.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Timed out after %0d cycles with %0d words outstanding",
             cycle_count, digest_due.size());
    $display("Test completed with failures");
    $finish;
  end

  // Sender: offers the next beat at the falling edge once the last one was taken.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (send_idx < stim_q.size() && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_data  <= stim_q[send_idx].beat;
        send_idx++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: one long hold-off over the burst of short messages, else random stalls.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!hold_started && accepted_cnt >= burst_at) begin
        hold_started = 1'b1;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Monitor: predict on accepted input beats, check accepted output beats.
  always @(posedge clk) begin
    md5_pkg::out_item_t want;
    logic [31:0]        word;
    cycle_count++;
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_valid && in_stall) begin
        stall_seen++;
      end
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        if (absorb_beat(in_data)) begin
          for (int k = 0; k < 4; k++) begin
            case (stim_q[accepted_cnt].src)
              EXP_EMPTY_MSG: word = EMPTY_DIGEST[k];
              EXP_ABC_MSG:   word = ABC_DIGEST[k];
              default:       word = digest_out[k];
            endcase
            digest_due.push_back('{word, 2'(k), k == 3});
          end
          messages_seen++;
        end
        accepted_cnt++;
      end
      if (out_valid && !out_stall) begin
        if (digest_due.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("[%0t] unexpected beat: word %h index %0d last %0b", $realtime,
                     out_data.digest_word, out_data.word_index, out_data.last_word);
          end
        end else begin
          want = digest_due.pop_front();
          words_checked++;
          if (out_data.digest_word !== want.digest_word ||
              out_data.word_index !== want.word_index ||
              out_data.last_word !== want.last_word) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("[%0t] mismatch: expected %h/%0d/%0b, got %h/%0d/%0b", $realtime,
                       want.digest_word, want.word_index, want.last_word,
                       out_data.digest_word, out_data.word_index, out_data.last_word);
            end
          end
        end
      end
    end
  end

  // Stimulus build, reset and end of run.
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    restart_message();
    block_buf = '{default: '0};

    foreach (DIRECTED[i]) stim_q.push_back(DIRECTED[i]);

    // Two short random messages, then a burst of tiny ones under the hold-off.
    for (int m = 0; m < 2; m++) add_message($urandom_range(0, 12), 1'($urandom_range(0, 1)));
    burst_at = stim_q.size();
    for (int m = 0; m < 6; m++) add_message($urandom_range(0, 2), 1'($urandom_range(0, 1)));

    // Length boundaries: length spilling into a second block, and a full block
    // closed by the end beat. No idling on either side through these.
    calm_from = stim_q.size();
    add_message(LENGTH_AT, 1'b0);
    add_message(BLOCK_LEN, 1'b1);
    calm_to = stim_q.size();

    while (stim_q.size() < TOTAL_BEATS) begin
      add_message($urandom_range(0, 12), 1'($urandom_range(0, 1)));
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt < stim_q.size()) @(posedge clk);
    while (digest_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d beats and %0d messages, %0d digest words checked.",
             accepted_cnt, messages_seen, words_checked);
    $display("Empty, spilling and full-block lengths included; input held off for %0d cycles.",
             stall_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d failures", fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
